### sv/htr_pkg.sv
package htr_pkg;

	localparam int MAX_ENTRIES       = 256;
	localparam int ID_BITS           = 8;
	localparam int CMD_BITS          = 3;
	localparam int STATUS_BITS       = 2;
	localparam int BYTES_BITS        = 32;
	localparam int LIVE_BITS         = 9;
	localparam int DEFAULT_SIZE_BITS = 24;
	localparam int DEFAULT_ADDR_BITS = 32;
	localparam int DEFAULT_REF_BITS  = 16;

	typedef enum logic [CMD_BITS-1:0] {
		CMD_ADD    = 3'd0,
		CMD_REMOVE = 3'd1,
		CMD_INC    = 3'd2,
		CMD_DEC    = 3'd3,
		CMD_FIND   = 3'd4,
		CMD_QUERY  = 3'd5
	} cmd_e_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK        = 2'd0,
		ST_NO_ENTRY  = 2'd1,
		ST_FULL      = 2'd2,
		ST_NO_VICTIM = 2'd3
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_in;
		logic fifo_rd;
		logic slot_rd_id;
		logic scan_init;
		logic scan_rd;
		logic scan_step;
		logic do_add;
		logic do_entry;
		logic do_scan_hit;
		logic do_scan_miss;
		logic do_misc;
	} ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		cmd_e_t cmd;
		logic   fifo_nonempty;
		logic   scan_hit;
		logic   scan_last;
		logic   out_free;
	} sts_t;

endpackage

### sv/handle_table_with_id_recycling_core.sv
// Handle table with id recycling.
// Commands arrive on the slave stream: s_tuser carries the command, s_tdata the entry id,
// size and heap address. Each command gives exactly one result beat on the master stream:
// m_tuser carries the status, m_tdata the result id, bytes in use, live count and the
// stored address, size and reference count of the entry concerned.
// The cfg channel writes the first fresh id; write it only while no command is in flight.
// One command is processed at a time. Add, remove, reference changes, query and unknown
// commands raise m_tvalid once the update state loads the result register. The dispatch
// state before it starts one registered read of the free-id ring (add, when the ring
// holds an id) or of the entry memory (remove, reference changes, query); unknown
// commands read nothing. Find-victim reads the entry memory one entry at a time from
// id 1 upward, examining at most 255 ids. s_tready is high only while idle, so a new
// command is accepted only after the previous one has loaded its result.
// The result sits in an output register; s_tready returns as soon as that register is
// loaded, so the next command is taken while a result waits. If the receiver stalls,
// the following command finishes its work but waits to load its result.
// Reset clears all valid bits, the free-id ring, the byte total and the fresh id counter
// at once; no clearing pass is needed and commands are taken straight after reset.
module handle_table_with_id_recycling_core import htr_pkg::*; #(
	parameter int SIZE_BITS = DEFAULT_SIZE_BITS,
	parameter int ADDR_BITS = DEFAULT_ADDR_BITS,
	parameter int REF_BITS  = DEFAULT_REF_BITS,
	parameter int IN_W      = ((ID_BITS + SIZE_BITS + ADDR_BITS + 7) / 8) * 8,
	parameter int OUT_W     = ((ID_BITS + BYTES_BITS + LIVE_BITS + ADDR_BITS + SIZE_BITS
		+ REF_BITS + 7) / 8) * 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_W-1:0]        s_tdata,  // entry_id, data_size, data_address
	input  logic [CMD_BITS-1:0]    s_tuser,  // command
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// result_id, bytes_in_use, live_count, entry_location, entry_size, reference_count
	output logic [OUT_W-1:0]       m_tdata,
	output logic [STATUS_BITS-1:0] m_tuser,  // status
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [ID_BITS-1:0]     cfg_data
);

	localparam int OUT_USED = ID_BITS + BYTES_BITS + LIVE_BITS + ADDR_BITS + SIZE_BITS + REF_BITS;

	ctl_t ctl;
	sts_t sts;

	logic [ID_BITS-1:0]    out_id;
	logic [BYTES_BITS-1:0] out_bytes;
	logic [LIVE_BITS-1:0]  out_live;
	logic [ADDR_BITS-1:0]  out_loc;
	logic [SIZE_BITS-1:0]  out_size;
	logic [REF_BITS-1:0]   out_refs;

	assign cfg_ready = 1'b1;

	htr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.ctl      (ctl)
	);

	htr_dpath #(
		.SIZE_BITS (SIZE_BITS),
		.ADDR_BITS (ADDR_BITS),
		.REF_BITS  (REF_BITS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_cmd     (s_tuser),
		.in_id      (s_tdata[ID_BITS-1:0]),
		.in_size    (s_tdata[ID_BITS+SIZE_BITS-1:ID_BITS]),
		.in_addr    (s_tdata[ID_BITS+SIZE_BITS+ADDR_BITS-1:ID_BITS+SIZE_BITS]),
		.cfg_we     (cfg_valid & cfg_ready),
		.cfg_data   (cfg_data),
		.ctl        (ctl),
		.sts        (sts),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.out_id     (out_id),
		.out_status (m_tuser),
		.out_bytes  (out_bytes),
		.out_live   (out_live),
		.out_loc    (out_loc),
		.out_size   (out_size),
		.out_refs   (out_refs)
	);

	assign m_tdata = OUT_W'({out_refs, out_size, out_loc, out_live, out_bytes, out_id});

	a_width: assert property (@(posedge clk) OUT_W >= OUT_USED)
		else $error("result bus too narrow");

endmodule

### sv/htr_ctrl.sv
module htr_ctrl import htr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output ctl_t ctl
);

	typedef enum logic [6:0] {
		S_IDLE     = 7'b0000001,
		S_DISPATCH = 7'b0000010,
		S_ADD      = 7'b0000100,
		S_ENTRY    = 7'b0001000,
		S_SCAN_RD  = 7'b0010000,
		S_SCAN_CHK = 7'b0100000,
		S_MISC     = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.load_in = 1'b1;
					state_d     = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				unique case (sts.cmd) inside
					CMD_ADD: begin
						ctl.fifo_rd = sts.fifo_nonempty;
						state_d     = S_ADD;
					end
					CMD_REMOVE, CMD_INC, CMD_DEC, CMD_QUERY: begin
						ctl.slot_rd_id = 1'b1;
						state_d        = S_ENTRY;
					end
					CMD_FIND: begin
						ctl.scan_init = 1'b1;
						state_d       = S_SCAN_RD;
					end
					default: state_d = S_MISC;
				endcase
			end
			S_ADD: begin
				if (sts.out_free) begin
					ctl.do_add = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_ENTRY: begin
				if (sts.out_free) begin
					ctl.do_entry = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_SCAN_RD: begin
				ctl.scan_rd = 1'b1;
				state_d     = S_SCAN_CHK;
			end
			S_SCAN_CHK: begin
				if (sts.scan_hit) begin
					if (sts.out_free) begin
						ctl.do_scan_hit = 1'b1;
						state_d         = S_IDLE;
					end
				end else if (sts.scan_last) begin
					if (sts.out_free) begin
						ctl.do_scan_miss = 1'b1;
						state_d          = S_IDLE;
					end
				end else begin
					ctl.scan_step = 1'b1;
					state_d       = S_SCAN_RD;
				end
			end
			S_MISC: begin
				if (sts.out_free) begin
					ctl.do_misc = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### sv/htr_dpath.sv
module htr_dpath import htr_pkg::*; #(
	parameter int SIZE_BITS = DEFAULT_SIZE_BITS,
	parameter int ADDR_BITS = DEFAULT_ADDR_BITS,
	parameter int REF_BITS  = DEFAULT_REF_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [CMD_BITS-1:0]    in_cmd,
	input  logic [ID_BITS-1:0]     in_id,
	input  logic [SIZE_BITS-1:0]   in_size,
	input  logic [ADDR_BITS-1:0]   in_addr,
	input  logic                   cfg_we,
	input  logic [ID_BITS-1:0]     cfg_data,
	input  ctl_t                   ctl,
	output sts_t                   sts,
	input  logic                   out_ready,
	output logic                   out_valid,
	output logic [ID_BITS-1:0]     out_id,
	output logic [STATUS_BITS-1:0] out_status,
	output logic [BYTES_BITS-1:0]  out_bytes,
	output logic [LIVE_BITS-1:0]   out_live,
	output logic [ADDR_BITS-1:0]   out_loc,
	output logic [SIZE_BITS-1:0]   out_size,
	output logic [REF_BITS-1:0]    out_refs
);

	localparam int SW = SIZE_BITS + ADDR_BITS + REF_BITS;
	localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};
	localparam logic [ID_BITS-1:0] LAST_ID = ID_BITS'(MAX_ENTRIES - 1);

	cmd_e_t                 cmd_q;
	logic [ID_BITS-1:0]     id_q;
	logic [SIZE_BITS-1:0]   size_q;
	logic [ADDR_BITS-1:0]   addr_q;

	logic [SW-1:0]          slot_mem [MAX_ENTRIES];
	logic [SW-1:0]          slot_rd_q;
	logic [ID_BITS-1:0]     fifo_mem [MAX_ENTRIES];
	logic [ID_BITS-1:0]     fifo_rd_q;
	logic [MAX_ENTRIES-1:0] valid_q;

	logic [LIVE_BITS-1:0]   nfresh_q, nfresh_d;
	logic [ID_BITS-1:0]     head_q, head_d, tail_q, tail_d, scan_q;
	logic [LIVE_BITS-1:0]   fcount_q, fcount_d;
	logic [BYTES_BITS-1:0]  total_q, total_d;

	logic [SIZE_BITS-1:0]   rd_size;
	logic [ADDR_BITS-1:0]   rd_loc;
	logic [REF_BITS-1:0]    rd_refs, refs_new;
	logic                   known, alloc_fifo, alloc_fresh, out_load;
	logic [ID_BITS-1:0]     nid, slot_wa, rd_addr;
	logic [SW-1:0]          slot_wd;
	logic                   slot_we, fifo_we, valid_set, valid_clr;
	logic [ID_BITS-1:0]     valid_idx;
	logic [ID_BITS-1:0]     o_id;
	status_t                o_st;
	logic [ADDR_BITS-1:0]   o_loc;
	logic [SIZE_BITS-1:0]   o_size;
	logic [REF_BITS-1:0]    o_refs;

	assign rd_size = slot_rd_q[SIZE_BITS-1:0];
	assign rd_loc  = slot_rd_q[SIZE_BITS+ADDR_BITS-1:SIZE_BITS];
	assign rd_refs = slot_rd_q[SW-1:SIZE_BITS+ADDR_BITS];
	assign known   = valid_q[id_q];
	assign rd_addr = ctl.scan_rd ? scan_q : id_q;

	assign alloc_fifo  = (fcount_q != '0);
	assign alloc_fresh = !alloc_fifo && !nfresh_q[LIVE_BITS-1];
	assign nid         = alloc_fifo ? fifo_rd_q : nfresh_q[ID_BITS-1:0];

	always_comb begin
		case (cmd_q)
			CMD_INC: refs_new = (rd_refs == REF_MAX) ? rd_refs : rd_refs + 1'b1;
			CMD_DEC: refs_new = (rd_refs == '0) ? rd_refs : rd_refs - 1'b1;
			default: refs_new = rd_refs;
		endcase
	end

	always_comb begin
		head_d    = head_q;
		tail_d    = tail_q;
		fcount_d  = fcount_q;
		nfresh_d  = nfresh_q;
		total_d   = total_q;
		slot_we   = 1'b0;
		slot_wa   = id_q;
		slot_wd   = {refs_new, rd_loc, rd_size};
		fifo_we   = 1'b0;
		valid_set = 1'b0;
		valid_clr = 1'b0;
		valid_idx = id_q;
		o_id      = '0;
		o_st      = ST_OK;
		o_loc     = '0;
		o_size    = '0;
		o_refs    = '0;
		if (ctl.do_add) begin
			if (alloc_fifo) begin
				head_d   = head_q + 1'b1;
				fcount_d = fcount_q - 1'b1;
			end else if (alloc_fresh) begin
				nfresh_d = nfresh_q + 1'b1;
			end
			if (alloc_fifo || alloc_fresh) begin
				slot_we   = 1'b1;
				slot_wa   = nid;
				slot_wd   = {{REF_BITS{1'b0}}, addr_q, size_q};
				valid_set = 1'b1;
				valid_idx = nid;
				total_d   = total_q + BYTES_BITS'(size_q);
				o_id      = nid;
				o_loc     = addr_q;
				o_size    = size_q;
			end else begin
				o_st = ST_FULL;
			end
		end
		if (ctl.do_entry) begin
			if (!known) begin
				o_st = ST_NO_ENTRY;
			end else begin
				o_id   = id_q;
				o_loc  = rd_loc;
				o_size = rd_size;
				o_refs = refs_new;
				if (cmd_q == CMD_INC || cmd_q == CMD_DEC) begin
					slot_we = 1'b1;
				end
				if (cmd_q == CMD_REMOVE) begin
					total_d   = total_q - BYTES_BITS'(rd_size);
					valid_clr = 1'b1;
					// A full ring drops the id; only reachable after a reconfiguration.
					if (!fcount_q[LIVE_BITS-1]) begin
						fifo_we  = 1'b1;
						tail_d   = tail_q + 1'b1;
						fcount_d = fcount_q + 1'b1;
					end
				end
			end
		end
		if (ctl.do_scan_hit) begin
			o_id   = scan_q;
			o_loc  = rd_loc;
			o_size = rd_size;
			o_refs = rd_refs;
		end
		if (ctl.do_scan_miss) begin
			o_st = ST_NO_VICTIM;
		end
	end

	assign out_load = ctl.do_add | ctl.do_entry | ctl.do_scan_hit | ctl.do_scan_miss |
		ctl.do_misc;

	always_ff @(posedge clk) begin
		if (slot_we) begin
			slot_mem[slot_wa] <= slot_wd;
		end
		if (ctl.slot_rd_id || ctl.scan_rd) begin
			slot_rd_q <= slot_mem[rd_addr];
		end
		if (fifo_we) begin
			fifo_mem[tail_q] <= id_q;
		end
		if (ctl.fifo_rd) begin
			fifo_rd_q <= fifo_mem[head_q];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_in) begin
			cmd_q  <= cmd_e_t'(in_cmd);
			id_q   <= in_id;
			size_q <= in_size;
			addr_q <= in_addr;
		end
		if (ctl.scan_init) begin
			scan_q <= ID_BITS'(1);
		end else if (ctl.scan_step) begin
			scan_q <= scan_q + 1'b1;
		end
		if (out_load) begin
			out_id     <= o_id;
			out_status <= o_st;
			out_bytes  <= total_d;
			out_live   <= nfresh_d - fcount_d;
			out_loc    <= o_loc;
			out_size   <= o_size;
			out_refs   <= o_refs;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			nfresh_q  <= '0;
			head_q    <= '0;
			tail_q    <= '0;
			fcount_q  <= '0;
			total_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			if (valid_set) begin
				valid_q[valid_idx] <= 1'b1;
			end else if (valid_clr) begin
				valid_q[valid_idx] <= 1'b0;
			end
			nfresh_q  <= cfg_we ? {1'b0, cfg_data} : nfresh_d;
			head_q    <= head_d;
			tail_q    <= tail_d;
			fcount_q  <= fcount_d;
			total_q   <= total_d;
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	assign sts.cmd           = cmd_q;
	assign sts.fifo_nonempty = alloc_fifo;
	assign sts.scan_hit      = valid_q[scan_q] && (rd_loc != '0) && (rd_size >= size_q);
	assign sts.scan_last     = (scan_q == LAST_ID);
	assign sts.out_free      = !out_valid || out_ready;

	a_fcount_range: assert property (@(posedge clk) disable iff (!arst_n)
		fcount_q <= LIVE_BITS'(MAX_ENTRIES))
		else $error("free ring count beyond capacity");

	a_ring_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		ID_BITS'(tail_q - head_q) == fcount_q[ID_BITS-1:0])
		else $error("free ring pointers disagree with count");

	a_one_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.do_add, ctl.do_entry, ctl.do_scan_hit, ctl.do_scan_miss, ctl.do_misc}))
		else $error("more than one command finishing at once");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !out_valid || out_ready)
		else $error("result overwritten before it was taken");

endmodule

### tb/handle_table_with_id_recycling_core_tb.sv
module handle_table_with_id_recycling_core_tb import htr_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IN_W  = 64;
	localparam int OUT_W = 128;
	localparam longint CYCLE_LIMIT = 3000000;

	typedef struct {
		logic [ID_BITS-1:0]    rid;
		status_t               st;
		logic [BYTES_BITS-1:0] bytes;
		logic [LIVE_BITS-1:0]  live;
		logic [31:0]           loc;
		logic [23:0]           sz;
		logic [15:0]           refs;
	} table_result_t;

	class handle_table_sb;
		bit                    valid [MAX_ENTRIES];
		logic [23:0]           size_q [MAX_ENTRIES];
		logic [31:0]           addr_q [MAX_ENTRIES];
		logic [15:0]           refs_q [MAX_ENTRIES];
		logic [ID_BITS-1:0]    freed [MAX_ENTRIES];
		logic [8:0]            fresh_id;
		logic [7:0]            head, tail;
		logic [8:0]            freed_cnt;
		logic [31:0]           total;
		table_result_t         awaited [$];
		int                    errors, checked, full_seen, victim_hits;

		function void clear();
			foreach (valid[i]) valid[i] = 0;
			fresh_id = 0; head = 0; tail = 0; freed_cnt = 0; total = 0;
			errors = 0; checked = 0; full_seen = 0; victim_hits = 0;
		endfunction

		function void set_first_fresh(logic [7:0] v);
			fresh_id = {1'b0, v};
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		// Returns a handle that is live right now, or a random id if none is.
		function logic [7:0] pick_live();
			int start;
			start = $urandom_range(0, MAX_ENTRIES - 1);
			for (int k = 0; k < MAX_ENTRIES; k++)
				if (valid[(start + k) % MAX_ENTRIES]) return 8'((start + k) % MAX_ENTRIES);
			return 8'($urandom_range(0, 255));
		endfunction

		function void note_command(logic [2:0] cmd, logic [7:0] id, logic [23:0] size,
				logic [31:0] addr);
			table_result_t r;
			logic [7:0] nid;
			r.rid = 0; r.st = ST_OK; r.loc = 0; r.sz = 0; r.refs = 0;
			case (cmd)
				CMD_ADD: begin
					if (freed_cnt > 0 || fresh_id < MAX_ENTRIES) begin
						if (freed_cnt > 0) begin
							nid = freed[head];
							head++;
							freed_cnt--;
						end else begin
							nid = fresh_id[7:0];
							fresh_id++;
						end
						valid[nid] = 1; size_q[nid] = size; addr_q[nid] = addr;
						refs_q[nid] = 0;
						total += {8'd0, size};
						r.rid = nid; r.loc = addr; r.sz = size;
					end else begin
						r.st = ST_FULL;
						full_seen++;
					end
				end
				CMD_REMOVE, CMD_INC, CMD_DEC, CMD_QUERY: begin
					if (!valid[id]) begin
						r.st = ST_NO_ENTRY;
					end else begin
						r.rid = id;
						if (cmd == CMD_INC && refs_q[id] != 16'hFFFF) refs_q[id]++;
						if (cmd == CMD_DEC && refs_q[id] != 0) refs_q[id]--;
						r.loc = addr_q[id]; r.sz = size_q[id]; r.refs = refs_q[id];
						if (cmd == CMD_REMOVE) begin
							total -= {8'd0, size_q[id]};
							valid[id] = 0;
							if (freed_cnt < MAX_ENTRIES) begin
								freed[tail] = id;
								tail++;
								freed_cnt++;
							end
						end
					end
				end
				CMD_FIND: begin
					r.st = ST_NO_VICTIM;
					for (int i = 1; i < MAX_ENTRIES; i++) begin
						if (valid[i] && addr_q[i] != 0 && size_q[i] >= size) begin
							r.st = ST_OK; r.rid = 8'(i);
							r.loc = addr_q[i]; r.sz = size_q[i]; r.refs = refs_q[i];
							victim_hits++;
							break;
						end
					end
				end
				default: ;
			endcase
			r.bytes = total;
			r.live = fresh_id - freed_cnt;
			awaited.push_back(r);
		endfunction

		function void check_result(logic [OUT_W-1:0] d, logic [STATUS_BITS-1:0] st);
			table_result_t e;
			checked++;
			if (awaited.size() == 0) begin
				$error("result beat with nothing awaited");
				errors++;
				return;
			end
			e = awaited.pop_front();
			if (d[7:0] !== e.rid) begin
				$error("result_id: expected %0d, got %0d", e.rid, d[7:0]); errors++;
			end
			if (st !== e.st) begin
				$error("status: expected %0d, got %0d", e.st, st); errors++;
			end
			if (d[39:8] !== e.bytes) begin
				$error("bytes_in_use: expected %0d, got %0d", e.bytes, d[39:8]); errors++;
			end
			if (d[48:40] !== e.live) begin
				$error("live_count: expected %0d, got %0d", e.live, d[48:40]); errors++;
			end
			if (d[80:49] !== e.loc) begin
				$error("entry_location: expected %h, got %h", e.loc, d[80:49]); errors++;
			end
			if (d[104:81] !== e.sz) begin
				$error("entry_size: expected %0d, got %0d", e.sz, d[104:81]); errors++;
			end
			if (d[120:105] !== e.refs) begin
				$error("reference_count: expected %0d, got %0d", e.refs, d[120:105]);
				errors++;
			end
		endfunction
	endclass

	logic                   clk = 0;
	logic                   arst_n = 0;
	logic                   s_tvalid = 0;
	logic                   s_tready;
	logic [IN_W-1:0]        s_tdata = '0;
	logic [CMD_BITS-1:0]    s_tuser = '0;
	logic                   m_tvalid;
	logic                   m_tready = 0;
	logic [OUT_W-1:0]       m_tdata;
	logic [STATUS_BITS-1:0] m_tuser;
	logic                   cfg_valid = 0;
	logic                   cfg_ready;
	logic [ID_BITS-1:0]     cfg_data = '0;

	handle_table_sb sb = new();
	int     send_idle = 0;
	int     recv_idle = 0;
	longint cycles = 0;
	int     sent = 0;

	handle_table_with_id_recycling_core uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
		m_tready <= ($urandom_range(0, 99) >= recv_idle);
	end

	task automatic send_command(logic [2:0] cmd, logic [7:0] id, logic [23:0] size,
			logic [31:0] addr);
		if ($urandom_range(0, 99) < send_idle) begin
			s_tvalid <= 0;
			@(posedge clk);
			while ($urandom_range(0, 99) < send_idle) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= cmd;
		s_tdata <= {addr, size, id};
		do @(posedge clk); while (!s_tready);
		sb.note_command(cmd, id, size, addr);
		sent++;
	endtask

	// The table is written only once every result is back and the block has settled.
	task automatic write_first_fresh(logic [7:0] v);
		s_tvalid <= 0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_valid <= 1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		sb.set_first_fresh(v);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	task automatic random_command();
		logic [2:0]  cmd;
		logic [7:0]  id;
		logic [23:0] size;
		logic [31:0] addr;
		int          pick;
		pick = $urandom_range(0, 99);
		if (pick < 32) cmd = CMD_ADD;
		else if (pick < 46) cmd = CMD_REMOVE;
		else if (pick < 61) cmd = CMD_INC;
		else if (pick < 72) cmd = CMD_DEC;
		else if (pick < 82) cmd = CMD_FIND;
		else if (pick < 96) cmd = CMD_QUERY;
		else cmd = 3'($urandom_range(6, 7));
		id = ($urandom_range(0, 3) != 0) ? sb.pick_live() : 8'($urandom_range(0, 255));
		pick = $urandom_range(0, 9);
		if (pick < 7) size = 24'($urandom_range(0, 4096));
		else if (pick < 9) size = 24'($urandom);
		else size = 24'hFFFFFF;
		if (cmd == CMD_FIND && sb.valid[id] && $urandom_range(0, 1)) size = sb.size_q[id];
		addr = ($urandom_range(0, 6) == 0) ? 32'd0 : $urandom;
		send_command(cmd, id, size, addr);
	endtask

	initial begin
		logic [7:0] fresh_values [6];
		sb.clear();
		fresh_values = '{8'd0, 8'd255, 8'd240, 8'd3, 8'd0, 8'd128};
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		for (int phase = 0; phase < 6; phase++) begin
			write_first_fresh(phase == 5 ? 8'($urandom_range(1, 254)) : fresh_values[phase]);
			case (phase % 3)
				0: begin send_idle = 20; recv_idle = 81; end
				1: begin send_idle = 81; recv_idle = 20; end
				default: begin send_idle = 0; recv_idle = 0; end
			endcase
			if (phase == 0) begin
				send_command(CMD_QUERY, 8'd0, 24'd0, 32'd0);
				send_command(CMD_FIND, 8'd0, 24'd0, 32'd0);
				send_command(CMD_ADD, 8'd0, 24'hFFFFFF, 32'hFFFFFFFF);
				send_command(CMD_ADD, 8'd0, 24'd0, 32'd0);
				send_command(CMD_ADD, 8'd0, 24'd100, 32'h1000);
				send_command(CMD_INC, 8'd0, 24'd0, 32'd0);
				send_command(CMD_INC, 8'd0, 24'd0, 32'd0);
				send_command(CMD_DEC, 8'd1, 24'd0, 32'd0);
				send_command(CMD_DEC, 8'd0, 24'd0, 32'd0);
				send_command(CMD_QUERY, 8'd0, 24'd0, 32'd0);
				send_command(CMD_FIND, 8'd0, 24'd0, 32'd0);
				send_command(CMD_FIND, 8'd0, 24'd101, 32'd0);
				send_command(CMD_FIND, 8'd0, 24'hFFFFFF, 32'd0);
				send_command(3'd6, 8'hFF, 24'hFFFFFF, 32'hFFFFFFFF);
				send_command(3'd7, 8'd0, 24'd0, 32'd0);
				send_command(CMD_REMOVE, 8'd255, 24'd0, 32'd0);
				send_command(CMD_INC, 8'd200, 24'd0, 32'd0);
				send_command(CMD_REMOVE, 8'd2, 24'd0, 32'd0);
				send_command(CMD_QUERY, 8'd2, 24'd0, 32'd0);
				send_command(CMD_REMOVE, 8'd0, 24'd0, 32'd0);
				send_command(CMD_ADD, 8'd0, 24'd7, 32'h55);
				send_command(CMD_ADD, 8'd0, 24'd8, 32'h66);
				send_command(CMD_FIND, 8'd0, 24'd0, 32'd0);
			end
			// Rewriting the first fresh id onto live handles makes adds overwrite them.
			repeat (290) random_command();
		end
		s_tvalid <= 0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (600) @(posedge clk);
		$display("Sent %0d commands over six first-id settings, checked %0d results.",
			sent, sb.checked);
		$display("Table-full answers: %0d, victims found: %0d.", sb.full_seen,
			sb.victim_hits);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule

### handle_table_with_id_recycling_core.f
sv/htr_pkg.sv
sv/htr_ctrl.sv
sv/htr_dpath.sv
sv/handle_table_with_id_recycling_core.sv
tb/handle_table_with_id_recycling_core_tb.sv
